>>> rtl/core/pids_pkg.sv
// ----------------------------------------------------------------------------
// pids_pkg
// Shared types and constants for the positional insert/delete store.
// ----------------------------------------------------------------------------
package pids_pkg;

  localparam int DATA_W           = 32;
  localparam int POS_W            = 5;
  localparam int CNT_OUT_W        = 5;
  localparam int DEFAULT_CAPACITY = 16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // broadcast to every cell; ins/del/rd set only for accepted, valid requests
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rd;
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

endpackage

>>> rtl/core/positional_insert_delete_store_core.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_store_core
// Ordered store of signed 32-bit entries with insert, delete, read and clear
// at 1-based positions, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_* stream: s_tuser carries the request type,
//   s_tdata the position and the value. Each request gives one result on
//   the m_* stream: status, read value (zero unless a good read) and the
//   element count after the request.
//   Throughput is one request per cycle while results are taken: all cells
//   shift in parallel, so an insert or delete completes in the cycle it is
//   accepted. The result is registered in the output register on acceptance.
//   A read selects its slot through an AND-OR over all cells.
//   A bad position or an insert into a full store is rejected and changes
//   nothing. Reset empties the store (count to zero) and drops any pending
//   result; cell contents are not cleared. When the receiver stalls, the
//   result holds in the output register and s_tready stays low until it is
//   taken; a new request is taken in the same cycle the old result leaves.
// ----------------------------------------------------------------------------
module positional_insert_delete_store_core #(
  parameter int CAPACITY = pids_pkg::DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // position[4:0], value[36:5], zero pad
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // status[1:0], read_value[33:2],
                                // element_count[38:34], zero pad
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > pids_pkg::POS_W) ? CW : pids_pkg::POS_W) + 1;
  localparam int DW   = pids_pkg::DATA_W;

  logic                          fire;
  pids_pkg::req_t                req;
  logic [pids_pkg::POS_W-1:0]    pos;
  logic [DW-1:0]                 ins_value;
  logic [CMPW-1:0]               pos_c;
  logic [CMPW-1:0]               cnt_c;
  logic                          ins_bad;
  logic                          acc_bad;
  logic                          full;

  logic [CW-1:0]                 cnt;
  logic [CW-1:0]                 cnt_next;
  pids_pkg::status_t             status_next;
  pids_pkg::cell_cmd_t           cmd;

  logic [DW-1:0]                 cell_value [CAPACITY];
  logic [DW-1:0]                 cell_rd    [CAPACITY];
  logic [DW-1:0]                 rd_any;

  pids_pkg::status_t             m_status;
  logic [DW-1:0]                 m_rdata;
  logic [pids_pkg::CNT_OUT_W-1:0] m_count;

  assign s_tready  = !m_tvalid || m_tready;
  assign fire      = s_tvalid && s_tready;
  assign req       = pids_pkg::req_t'(s_tuser);
  assign pos       = s_tdata[4:0];
  assign ins_value = s_tdata[36:5];

  assign pos_c   = CMPW'(pos);
  assign cnt_c   = CMPW'(cnt);
  assign ins_bad = (pos == '0) || (pos_c > (cnt_c + CMPW'(1)));
  assign acc_bad = (pos == '0) || (pos_c > cnt_c);
  assign full    = (cnt == CW'(CAPACITY));

  always_comb begin
    cmd         = '0;
    cmd.pos     = pos;
    cnt_next    = cnt;
    status_next = pids_pkg::ST_OK;
    case (req)
      pids_pkg::REQ_INSERT: begin
        if (ins_bad) begin
          status_next = pids_pkg::ST_BAD_POS;
        end else if (full) begin
          status_next = pids_pkg::ST_FULL;
        end else begin
          cmd.ins  = fire;
          cnt_next = cnt + CW'(1);
        end
      end
      pids_pkg::REQ_DELETE: begin
        if (acc_bad) begin
          status_next = pids_pkg::ST_BAD_POS;
        end else begin
          cmd.del  = fire;
          cnt_next = cnt - CW'(1);
        end
      end
      pids_pkg::REQ_READ: begin
        if (acc_bad) begin
          status_next = pids_pkg::ST_BAD_POS;
        end else begin
          cmd.rd = fire;
        end
      end
      pids_pkg::REQ_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
        status_next = pids_pkg::ST_BAD_POS;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_value;
    logic [DW-1:0] right_value;
    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_mid_l
      assign left_value = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_mid_r
      assign right_value = cell_value[i+1];
    end
    pids_cell #(
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .ins_value   (ins_value),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[i]),
      .rd_data     (cell_rd[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        cnt      <= cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_status <= status_next;
      m_rdata  <= rd_any;
      m_count  <= pids_pkg::CNT_OUT_W'(cnt_next);
    end
  end

  assign m_tdata = {1'b0, m_count, m_rdata, m_status};

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_status != pids_pkg::ST_OK) |-> (m_rdata == '0))
    else $error("rejected request returned nonzero data");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    fire && (req == pids_pkg::REQ_CLEAR) |=> (cnt == '0) && (m_count == '0))
    else $error("clear did not empty the store");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request taken while result stalled");

endmodule

>>> rtl/core/pids_cell.sv
// ----------------------------------------------------------------------------
// pids_cell
// One slot of the store: holds one entry, shifts from its left neighbor on
// insert, from its right neighbor on delete, and answers reads of its slot.
// ----------------------------------------------------------------------------
module pids_cell #(
  parameter int INDEX = 0
) (
  input  logic                           clk,
  input  pids_pkg::cell_cmd_t            cmd,
  input  logic [pids_pkg::DATA_W-1:0]    ins_value,
  input  logic [pids_pkg::DATA_W-1:0]    left_value,
  input  logic [pids_pkg::DATA_W-1:0]    right_value,
  output logic [pids_pkg::DATA_W-1:0]    value,
  output logic [pids_pkg::DATA_W-1:0]    rd_data
);

  localparam int SW = ($clog2(INDEX + 2) > pids_pkg::POS_W) ?
                      $clog2(INDEX + 2) : pids_pkg::POS_W;

  logic [SW-1:0] slot;
  logic [SW-1:0] pos_w;
  logic          at_pos;
  logic          above_pos;

  assign slot      = SW'(INDEX + 1);
  assign pos_w     = SW'(cmd.pos);
  assign at_pos    = (slot == pos_w);
  assign above_pos = (slot > pos_w);

  always_ff @(posedge clk) begin
    if (cmd.ins && at_pos) begin
      value <= ins_value;
    end else if (cmd.ins && above_pos) begin
      value <= left_value;
    end else if (cmd.del && (at_pos || above_pos)) begin
      value <= right_value;
    end
  end

  assign rd_data = (cmd.rd && at_pos) ? value : '0;

endmodule
